@@ hdl/lhxb_pkg.sv @@
package lhxb_pkg;

	// action codes of the input item
	localparam logic [1:0] ACT_OFFSET = 2'd0;
	localparam logic [1:0] ACT_BEAM   = 2'd1;
	localparam logic [1:0] ACT_HIT    = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	// fixed-point constants
	localparam logic signed [25:0] ANG_LIMIT       = 26'sd23592960;
	localparam logic [30:0]        DEG2RAD_Q32     = 31'd1199381129;
	localparam logic signed [35:0] PI_Q30          = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30      = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q30     = 36'sd1686629713;
	localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

	typedef struct packed {
		logic cap;
		logic set_ofs;
		logic set_beam;
		logic inc_idx;
		logic d2r_mul;
		logic d2r_az;
		logic wr_zen;
		logic wr_az;
		logic cord_init;
		logic cord_az;
		logic cord_step;
		logic store_zen;
		logic store_az;
		logic dir_mul;
		logic dir_rnd;
		logic hit_mul;
		logic hit_sum;
		logic emit;
	} lhxb_cmd_t;

	typedef struct packed {
		logic hit_ok;
		logic cord_last;
		logic in_box;
	} lhxb_stat_t;

	// truncated Q30 arctangent of 2^-i
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0: v = 32'd843314856;
			5'd1: v = 32'd497837829;
			5'd2: v = 32'd263043836;
			5'd3: v = 32'd133525158;
			5'd4: v = 32'd67021686;
			5'd5: v = 32'd33543515;
			5'd6: v = 32'd16775850;
			5'd7: v = 32'd8388437;
			5'd8: v = 32'd4194282;
			5'd9: v = 32'd2097149;
			5'd10: v = 32'd1048575;
			5'd11: v = 32'd524287;
			5'd12: v = 32'd262143;
			5'd13: v = 32'd131071;
			5'd14: v = 32'd65535;
			5'd15: v = 32'd32767;
			5'd16: v = 32'd16383;
			5'd17: v = 32'd8191;
			5'd18: v = 32'd4095;
			5'd19: v = 32'd2047;
			5'd20: v = 32'd1023;
			5'd21: v = 32'd511;
			5'd22: v = 32'd255;
			5'd23: v = 32'd127;
			5'd24: v = 32'd63;
			5'd25: v = 32'd31;
			5'd26: v = 32'd15;
			5'd27: v = 32'd8;
			5'd28: v = 32'd4;
			5'd29: v = 32'd2;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// round a Q60 product to Q30, halves away from zero
	function automatic logic signed [31:0] rnd30_64(input logic signed [63:0] p);
		logic [63:0] mag;
		logic [63:0] r;
		mag = p[63] ? 64'(-p) : 64'(p);
		r = (mag + 64'(1 << 29)) >> 30;
		return p[63] ? -$signed(r[31:0]) : $signed(r[31:0]);
	endfunction

	// round range times coefficient down by 2^30, halves away from zero
	function automatic logic signed [23:0] rnd30_53(input logic signed [52:0] p);
		logic [52:0] mag;
		logic [52:0] r;
		mag = p[52] ? 53'(-p) : 53'(p);
		r = (mag + 53'(1 << 29)) >> 30;
		return p[52] ? -$signed(r[23:0]) : $signed(r[23:0]);
	endfunction

	// clamp a 50-bit sum to the signed 48-bit range
	function automatic logic signed [47:0] sat48(input logic signed [49:0] s);
		logic signed [47:0] v;
		if (s[49:47] == 3'b000 || s[49:47] == 3'b111) begin
			v = s[47:0];
		end else if (s[49]) begin
			v = {1'b1, 47'd0};
		end else begin
			v = {1'b0, {47{1'b1}}};
		end
		return v;
	endfunction

endpackage

@@ hdl/lidar_hit_to_xyz_box_filter.sv @@
// Laser-scanner hit to Cartesian point converter with box filter.
// Input channel (in_valid/in_ready) carries one item per transfer, chosen
// by action: scan offset, beam header or hit. Output channel
// (out_valid/out_ready) carries one point per kept hit.
// Configuration: cfg_wr_en writes cfg_data to box register cfg_index
// (min x, y, z, then max x, y, z). The user must write only while the
// block is idle; the block itself does not enforce it. An offset item
// needs only its transfer. A hit goes through transfer, multiply, round
// and add, box test; a kept point then goes to the output register. A
// beam item runs the single CORDIC unit for the zenith, then the azimuth
// sine and cosine, one rotation per cycle; in_ready is low until it ends.
// Hits beyond the beam's count and points outside the box give nothing.
// Reset clears the box, offsets, beam state and output valid.
// A stalled receiver leaves the point in the output register; the block still
// takes the next item, and a second kept point waits in the box test until
// the register frees.
module lidar_hit_to_xyz_box_filter import lhxb_pkg::*; #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [25:0] zenith_deg,
	input  logic signed [25:0] azimuth_deg,
	input  logic signed [47:0] pos_x,
	input  logic signed [47:0] pos_y,
	input  logic signed [47:0] pos_z,
	input  logic [7:0]         hits_in_beam,
	input  logic [19:0]        hit_range,
	input  logic [31:0]        hit_reflectance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] point_x,
	output logic signed [47:0] point_y,
	output logic signed [47:0] point_z,
	output logic [31:0]        out_reflectance,
	output logic [7:0]         hit_number,
	output logic [7:0]         out_hit_count,
	output logic signed [23:0] zenith_rad,
	output logic signed [23:0] azimuth_rad,
	output logic [19:0]        out_range
);

	lhxb_cmd_t  cmd;
	lhxb_stat_t st;

	lhxb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	lhxb_datapath #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.zenith_deg      (zenith_deg),
		.azimuth_deg     (azimuth_deg),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.hits_in_beam    (hits_in_beam),
		.hit_range       (hit_range),
		.hit_reflectance (hit_reflectance),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_z         (point_z),
		.out_reflectance (out_reflectance),
		.hit_number      (hit_number),
		.out_hit_count   (out_hit_count),
		.zenith_rad      (zenith_rad),
		.azimuth_rad     (azimuth_rad),
		.out_range       (out_range)
	);

endmodule

@@ hdl/lhxb_datapath.sv @@
module lhxb_datapath import lhxb_pkg::*; #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lhxb_cmd_t           cmd,
	output lhxb_stat_t          st,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [47:0]         cfg_data,
	input  logic signed [25:0]  zenith_deg,
	input  logic signed [25:0]  azimuth_deg,
	input  logic signed [47:0]  pos_x,
	input  logic signed [47:0]  pos_y,
	input  logic signed [47:0]  pos_z,
	input  logic [7:0]          hits_in_beam,
	input  logic [19:0]         hit_range,
	input  logic [31:0]         hit_reflectance,
	output logic signed [47:0]  point_x,
	output logic signed [47:0]  point_y,
	output logic signed [47:0]  point_z,
	output logic [31:0]         out_reflectance,
	output logic [7:0]          hit_number,
	output logic [7:0]          out_hit_count,
	output logic signed [23:0]  zenith_rad,
	output logic signed [23:0]  azimuth_rad,
	output logic [19:0]         out_range
);

	localparam int CW = $clog2(CORDIC_STEPS);

	logic signed [47:0] box_min_x_q, box_min_y_q, box_min_z_q;
	logic signed [47:0] box_max_x_q, box_max_y_q, box_max_z_q;
	logic signed [47:0] ofs_x_q, ofs_y_q, ofs_z_q;
	logic signed [47:0] org_x_q, org_y_q, org_z_q;
	logic signed [23:0] zen_q, az_q;
	logic [7:0]         total_q, idx_q;
	logic signed [31:0] dir_x_q, dir_y_q, dir_z_q;

	// held copy of the current item
	logic signed [25:0] zen_h_q, az_h_q;
	logic [7:0]         hidx_q;
	logic [19:0]        rng_h_q;
	logic [31:0]        refl_h_q;

	// degree to radian
	logic signed [25:0] d_sel, d_clamp;
	logic [24:0]        d_mag;
	logic [55:0]        d2r_p_q;
	logic               d2r_neg_q;
	logic [55:0]        d_rnd;
	logic signed [23:0] d_rad;

	// CORDIC
	logic signed [33:0] cx_q, cy_q;
	logic signed [35:0] cz_q;
	logic               cneg_q;
	logic [CW-1:0]      cnt_q;
	logic signed [23:0] c_ang;
	logic signed [35:0] z0, z1, zi;
	logic               ni;
	logic signed [33:0] xs, ys;
	logic signed [35:0] at;
	logic signed [33:0] s_fin, c_fin;
	logic signed [31:0] sz_q, cz_s_q, sa_q, ca_q;

	// products and sums
	logic signed [63:0] px_dir_q, py_dir_q;
	logic signed [52:0] hp_x_q, hp_y_q, hp_z_q;
	logic signed [47:0] pt_x_q, pt_y_q, pt_z_q;
	logic signed [49:0] sx, sy, sz;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q <= '0;
			box_min_y_q <= '0;
			box_min_z_q <= '0;
			box_max_x_q <= '0;
			box_max_y_q <= '0;
			box_max_z_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MIN_X: box_min_x_q <= cfg_data;
				REG_MIN_Y: box_min_y_q <= cfg_data;
				REG_MIN_Z: box_min_z_q <= cfg_data;
				REG_MAX_X: box_max_x_q <= cfg_data;
				REG_MAX_Y: box_max_y_q <= cfg_data;
				REG_MAX_Z: box_max_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// scan and beam state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_x_q <= '0;
			ofs_y_q <= '0;
			ofs_z_q <= '0;
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			zen_q   <= '0;
			az_q    <= '0;
			total_q <= '0;
			idx_q   <= '0;
			dir_x_q <= '0;
			dir_y_q <= '0;
			dir_z_q <= '0;
		end else begin
			if (cmd.set_ofs) begin
				ofs_x_q <= pos_x;
				ofs_y_q <= pos_y;
				ofs_z_q <= pos_z;
			end
			if (cmd.set_beam) begin
				org_x_q <= pos_x;
				org_y_q <= pos_y;
				org_z_q <= pos_z;
				total_q <= hits_in_beam;
				idx_q   <= '0;
			end
			if (cmd.inc_idx) begin
				idx_q <= idx_q + 8'd1;
			end
			if (cmd.wr_zen) begin
				zen_q <= d_rad;
			end
			if (cmd.wr_az) begin
				az_q <= d_rad;
			end
			if (cmd.dir_rnd) begin
				dir_x_q <= rnd30_64(px_dir_q);
				dir_y_q <= rnd30_64(py_dir_q);
				dir_z_q <= cz_s_q;
			end
		end
	end

	// hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			zen_h_q  <= zenith_deg;
			az_h_q   <= azimuth_deg;
			hidx_q   <= idx_q;
			rng_h_q  <= hit_range;
			refl_h_q <= hit_reflectance;
		end
	end

	// clamp, take magnitude, scale by the degree-to-radian constant
	always_comb begin
		d_sel = cmd.d2r_az ? az_h_q : zen_h_q;
		if (d_sel > ANG_LIMIT) begin
			d_clamp = ANG_LIMIT;
		end else if (d_sel < -ANG_LIMIT) begin
			d_clamp = -ANG_LIMIT;
		end else begin
			d_clamp = d_sel;
		end
		d_mag = d_clamp[25] ? 25'(-d_clamp) : 25'(d_clamp);
		d_rnd = (d2r_p_q + 56'(64'd1 << 31)) >> 32;
		d_rad = d2r_neg_q ? -$signed(d_rnd[23:0]) : $signed(d_rnd[23:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.d2r_mul) begin
			d2r_p_q   <= 56'(d_mag) * 56'(DEG2RAD_Q32);
			d2r_neg_q <= d_clamp[25];
		end
	end

	// quadrant reduction of the start angle, step terms and final sign fix
	always_comb begin
		c_ang = cmd.cord_az ? az_q : zen_q;
		z0 = 36'(c_ang) <<< 10;
		if (z0 > PI_Q30) begin
			z1 = z0 - TWO_PI_Q30;
		end else if (z0 < -PI_Q30) begin
			z1 = z0 + TWO_PI_Q30;
		end else begin
			z1 = z0;
		end
		if (z1 > HALF_PI_Q30) begin
			zi = z1 - PI_Q30;
			ni = 1'b1;
		end else if (z1 < -HALF_PI_Q30) begin
			zi = z1 + PI_Q30;
			ni = 1'b1;
		end else begin
			zi = z1;
			ni = 1'b0;
		end
		xs = cx_q >>> cnt_q;
		ys = cy_q >>> cnt_q;
		at = $signed(36'(atan_q30(5'(cnt_q))));
		s_fin = cneg_q ? -cy_q : cy_q;
		c_fin = cneg_q ? -cx_q : cx_q;
	end

	// rotate one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cord_init) begin
			cnt_q <= '0;
		end else if (cmd.cord_step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cord_init) begin
			cx_q   <= CORDIC_INV_GAIN;
			cy_q   <= '0;
			cz_q   <= zi;
			cneg_q <= ni;
		end else if (cmd.cord_step) begin
			if (!cz_q[35]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end
		end
		if (cmd.store_zen) begin
			sz_q   <= s_fin[31:0];
			cz_s_q <= c_fin[31:0];
		end
		if (cmd.store_az) begin
			sa_q <= s_fin[31:0];
			ca_q <= c_fin[31:0];
		end
		if (cmd.dir_mul) begin
			px_dir_q <= 64'(sz_q) * 64'(ca_q);
			py_dir_q <= 64'(sz_q) * 64'(sa_q);
		end
	end

	assign st.cord_last = (cnt_q == CW'(CORDIC_STEPS - 1));
	assign st.hit_ok    = (idx_q < total_q);

	// hit: multiply, then round and add, then box test
	always_comb begin
		sx = 50'(rnd30_53(hp_x_q)) + 50'(org_x_q) + 50'(ofs_x_q);
		sy = 50'(rnd30_53(hp_y_q)) + 50'(org_y_q) + 50'(ofs_y_q);
		sz = 50'(rnd30_53(hp_z_q)) + 50'(org_z_q) + 50'(ofs_z_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.hit_mul) begin
			hp_x_q <= 53'($signed({1'b0, rng_h_q})) * 53'(dir_x_q);
			hp_y_q <= 53'($signed({1'b0, rng_h_q})) * 53'(dir_y_q);
			hp_z_q <= 53'($signed({1'b0, rng_h_q})) * 53'(dir_z_q);
		end
		if (cmd.hit_sum) begin
			pt_x_q <= sat48(sx);
			pt_y_q <= sat48(sy);
			pt_z_q <= sat48(sz);
		end
	end

	assign st.in_box = (pt_x_q >= box_min_x_q) && (pt_y_q >= box_min_y_q)
		&& (pt_z_q >= box_min_z_q) && (pt_x_q <= box_max_x_q)
		&& (pt_y_q <= box_max_y_q) && (pt_z_q <= box_max_z_q);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			point_x         <= pt_x_q;
			point_y         <= pt_y_q;
			point_z         <= pt_z_q;
			out_reflectance <= refl_h_q;
			hit_number      <= hidx_q;
			out_hit_count   <= total_q;
			zenith_rad      <= zen_q;
			azimuth_rad     <= az_q;
			out_range       <= rng_h_q;
		end
	end

endmodule

@@ hdl/lhxb_ctrl.sv @@
module lhxb_ctrl import lhxb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	output logic       out_valid,
	input  logic       out_ready,
	output lhxb_cmd_t  cmd,
	input  lhxb_stat_t st
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DZ   = 4'd1;
	localparam logic [3:0] S_DA   = 4'd2;
	localparam logic [3:0] S_CZI  = 4'd3;
	localparam logic [3:0] S_CZR  = 4'd4;
	localparam logic [3:0] S_CAI  = 4'd5;
	localparam logic [3:0] S_CAR  = 4'd6;
	localparam logic [3:0] S_DS   = 4'd7;
	localparam logic [3:0] S_DM   = 4'd8;
	localparam logic [3:0] S_DR   = 4'd9;
	localparam logic [3:0] S_HM   = 4'd10;
	localparam logic [3:0] S_HS   = 4'd11;
	localparam logic [3:0] S_HE   = 4'd12;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       in_xfer;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// decode state into datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					cmd.cap = 1'b1;
					unique case (action)
						ACT_OFFSET: cmd.set_ofs = 1'b1;
						ACT_BEAM: begin
							cmd.set_beam = 1'b1;
							state_d      = S_DZ;
						end
						ACT_HIT: begin
							if (st.hit_ok) begin
								cmd.inc_idx = 1'b1;
								state_d     = S_HM;
							end
						end
						default: ;
					endcase
				end
			end
			S_DZ: begin
				cmd.d2r_mul = 1'b1;
				state_d     = S_DA;
			end
			S_DA: begin
				cmd.wr_zen  = 1'b1;
				cmd.d2r_mul = 1'b1;
				cmd.d2r_az  = 1'b1;
				state_d     = S_CZI;
			end
			S_CZI: begin
				cmd.wr_az     = 1'b1;
				cmd.cord_init = 1'b1;
				state_d       = S_CZR;
			end
			S_CZR: begin
				cmd.cord_step = 1'b1;
				if (st.cord_last) begin
					state_d = S_CAI;
				end
			end
			S_CAI: begin
				cmd.store_zen = 1'b1;
				cmd.cord_init = 1'b1;
				cmd.cord_az   = 1'b1;
				state_d       = S_CAR;
			end
			S_CAR: begin
				cmd.cord_step = 1'b1;
				if (st.cord_last) begin
					state_d = S_DS;
				end
			end
			S_DS: begin
				cmd.store_az = 1'b1;
				state_d      = S_DM;
			end
			S_DM: begin
				cmd.dir_mul = 1'b1;
				state_d     = S_DR;
			end
			S_DR: begin
				cmd.dir_rnd = 1'b1;
				state_d     = S_IDLE;
			end
			S_HM: begin
				cmd.hit_mul = 1'b1;
				state_d     = S_HS;
			end
			S_HS: begin
				cmd.hit_sum = 1'b1;
				state_d     = S_HE;
			end
			S_HE: begin
				// drop points outside the box, hold while the output slot is full
				if (!st.in_box) begin
					state_d = S_IDLE;
				end else if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_hit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && action == ACT_HIT && st.hit_ok |=> state_q == S_HM)
		else $error("accepted hit did not start the hit sequence");

	a_offset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && action == ACT_OFFSET |=> state_q == S_IDLE)
		else $error("offset transfer left the idle state");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HE && st.in_box && out_valid_q && !out_ready
		|=> state_q == S_HE && out_valid_q)
		else $error("kept point lost while output stalled");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted point not presented");

endmodule

@@ verif/tb.sv @@
module tb;
	import lhxb_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 1000;
	localparam longint C48_MAX = 64'sd140737488355327;
	localparam longint C48_MIN = -64'sd140737488355328;

	typedef struct packed {
		logic [1:0]         act;
		logic signed [25:0] zen;
		logic signed [25:0] az;
		logic signed [47:0] px;
		logic signed [47:0] py;
		logic signed [47:0] pz;
		logic [7:0]         nhits;
		logic [19:0]        rng;
		logic [31:0]        refl;
	} scan_item_t;

	typedef struct packed {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic signed [47:0] z;
		logic [31:0]        refl;
		logic [7:0]         num;
		logic [7:0]         cnt;
		logic signed [23:0] zen;
		logic signed [23:0] az;
		logic [19:0]        rng;
	} point_t;

	// directed rows: either checked by the converter model or typed as "no point"
	typedef enum logic {ROW_MODEL, ROW_NO_POINT} row_kind_t;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_index;
	logic [47:0] cfg_data;
	logic in_valid, in_ready;
	logic [1:0] action;
	logic signed [25:0] zenith_deg, azimuth_deg;
	logic signed [47:0] pos_x, pos_y, pos_z;
	logic [7:0] hits_in_beam;
	logic [19:0] hit_range;
	logic [31:0] hit_reflectance;
	logic out_valid, out_ready;
	logic signed [47:0] point_x, point_y, point_z;
	logic [31:0] out_reflectance;
	logic [7:0] hit_number, out_hit_count;
	logic signed [23:0] zenith_rad, azimuth_rad;
	logic [19:0] out_range;

	lidar_hit_to_xyz_box_filter dut (.*);

	// converter model state
	longint box_lo[3], box_hi[3];
	longint scan_ofs[3], beam_org[3], beam_dir[3];
	longint beam_zen, beam_az;
	int unsigned beam_total, beam_idx;
	point_t points_due[$];
	int errors = 0;
	int idle_cycles = 0;
	bit sender_busy;
	int burst_left = 0;

	longint arctan_tab[20] = '{843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint round_down(longint v, int s);
		longint mag, r;
		mag = (v < 0) ? -v : v;
		r = (mag + (64'sd1 <<< (s - 1))) >>> s;
		return (v < 0) ? -r : r;
	endfunction

	function automatic longint deg_to_q20(logic signed [25:0] d);
		longint v;
		v = d;
		if (v > ANG_LIMIT) v = ANG_LIMIT;
		if (v < -longint'(ANG_LIMIT)) v = -longint'(ANG_LIMIT);
		return round_down(v * longint'(DEG2RAD_Q32), 32);
	endfunction

	task automatic rotate(input longint a20, output longint s, output longint c);
		longint z, x, y, nx;
		bit flip;
		z = a20 * 1024;
		x = CORDIC_INV_GAIN;
		y = 0;
		flip = 0;
		if (z > PI_Q30) z -= 2 * longint'(PI_Q30);
		if (z < -longint'(PI_Q30)) z += 2 * longint'(PI_Q30);
		if (z > longint'(PI_Q30) / 2) begin
			z -= PI_Q30;
			flip = 1;
		end else if (z < -(longint'(PI_Q30) / 2)) begin
			z += PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < 20; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_tab[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_tab[i];
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic longint clamp48(longint v);
		if (v > C48_MAX) return C48_MAX;
		if (v < C48_MIN) return C48_MIN;
		return v;
	endfunction

	// update the model for one transfer; sets kept when a point is due
	task automatic convert(input scan_item_t it, output bit kept, output point_t p);
		longint sz, cz, sa, ca, r, c[3];
		kept = 0;
		p = '0;
		case (it.act)
			ACT_OFFSET: begin
				scan_ofs = '{it.px, it.py, it.pz};
			end
			ACT_BEAM: begin
				beam_zen = deg_to_q20(it.zen);
				beam_az = deg_to_q20(it.az);
				beam_org = '{it.px, it.py, it.pz};
				beam_total = it.nhits;
				beam_idx = 0;
				rotate(beam_zen, sz, cz);
				rotate(beam_az, sa, ca);
				beam_dir[0] = round_down(sz * ca, 30);
				beam_dir[1] = round_down(sz * sa, 30);
				beam_dir[2] = cz;
			end
			ACT_HIT: begin
				if (beam_idx < beam_total) begin
					r = it.rng;
					for (int k = 0; k < 3; k++)
						c[k] = clamp48(round_down(r * beam_dir[k], 30) + beam_org[k] + scan_ofs[k]);
					kept = 1;
					for (int k = 0; k < 3; k++)
						if (c[k] < box_lo[k] || c[k] > box_hi[k]) kept = 0;
					p = '{c[0][47:0], c[1][47:0], c[2][47:0], it.refl, beam_idx[7:0],
						beam_total[7:0], beam_zen[23:0], beam_az[23:0], it.rng};
					beam_idx++;
				end
			end
			default: ;
		endcase
	endtask

	// write one box register while the block is idle
	task automatic write_box(input logic [2:0] idx, input longint val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val[47:0];
		if (idx < REG_MAX_X) box_lo[idx] = val;
		else box_hi[idx - REG_MAX_X] = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic set_box(input longint lo, input longint hi);
		write_box(REG_MIN_X, lo);
		write_box(REG_MIN_Y, lo);
		write_box(REG_MIN_Z, lo);
		write_box(REG_MAX_X, hi);
		write_box(REG_MAX_Y, hi);
		write_box(REG_MAX_Z, hi);
	endtask

	task automatic settle();
		while (points_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// present one item at the falling edge and hold it until the transfer
	task automatic send(input scan_item_t it, input row_kind_t kind);
		bit kept;
		point_t p;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		{action, zenith_deg, azimuth_deg, pos_x, pos_y, pos_z} =
			{it.act, it.zen, it.az, it.px, it.py, it.pz};
		{hits_in_beam, hit_range, hit_reflectance} = {it.nhits, it.rng, it.refl};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		convert(it, kept, p);
		if (kind == ROW_NO_POINT && kept) begin
			$display("%0t: row expects no point, model keeps x=%0d", $time, p.x);
			errors++;
		end
		if (kept) points_due.push_back(p);
	endtask

	function automatic scan_item_t mk(logic [1:0] act, logic signed [25:0] zen,
		logic signed [25:0] az, longint px, longint py, longint pz,
		logic [7:0] nh, logic [19:0] rng, logic [31:0] refl);
		scan_item_t it;
		it = '{act, zen, az, px[47:0], py[47:0], pz[47:0], nh, rng, refl};
		return it;
	endfunction

	function automatic scan_item_t rand_item(logic [1:0] act, bit far, logic [7:0] nh);
		scan_item_t it;
		it.act = act;
		if ($urandom_range(0, 7) == 0) begin
			it.zen = 26'($urandom());
			it.az = 26'($urandom());
		end else begin
			it.zen = 26'($signed($urandom_range(0, 47185920)) - 23592960);
			it.az = 26'($signed($urandom_range(0, 47185920)) - 23592960);
		end
		if (far) begin
			it.px = 48'({$urandom(), $urandom()});
			it.py = 48'({$urandom(), $urandom()});
			it.pz = 48'({$urandom(), $urandom()});
		end else begin
			it.px = 48'($signed($urandom_range(0, 2097152)) - 1048576);
			it.py = 48'($signed($urandom_range(0, 2097152)) - 1048576);
			it.pz = 48'($signed($urandom_range(0, 2097152)) - 1048576);
		end
		it.nhits = nh;
		it.rng = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 15)) : 20'($urandom());
		it.refl = $urandom();
		return it;
	endfunction

	// well-formed beams followed by their hits, with some noise and excess hits
	task automatic random_phase(input int n_items, input bit far);
		int sent;
		int nh;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 15))
				0: begin
					send(rand_item(ACT_OFFSET, far, 8'd0), ROW_MODEL);
					sent++;
				end
				1: send(rand_item(ACT_UNUSED, 1, 8'($urandom())), ROW_MODEL);
				default: begin
					nh = ($urandom_range(0, 30) == 0) ? $urandom_range(200, 255)
						: $urandom_range(0, 10);
					send(rand_item(ACT_BEAM, far, 8'(nh)), ROW_MODEL);
					sent++;
					for (int h = 0; h < nh + $urandom_range(0, 2); h++) begin
						send(rand_item(ACT_HIT, far, 8'($urandom())), ROW_MODEL);
						sent++;
					end
				end
			endcase
		end
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
	endtask

	// receiver: stretches of steady ready mixed with stretches of random stalls
	initial begin
		out_ready = 1'b0;
		forever begin
			int len;
			bit steady;
			len = $urandom_range(5, 120);
			steady = $urandom_range(0, 2) == 0;
			repeat (len) begin
				@(negedge clk);
				out_ready <= steady ? 1'b1 : ($urandom_range(0, 2) != 0);
			end
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// compare each point transfer with the oldest point due
	always @(posedge clk) begin
		point_t w;
		if (out_valid && out_ready) begin
			if (points_due.size() == 0) begin
				$display("%0t: point x=%0d with none due", $time, point_x);
				errors++;
			end else begin
				w = points_due.pop_front();
				check_field("point_x", w.x, point_x);
				check_field("point_y", w.y, point_y);
				check_field("point_z", w.z, point_z);
				check_field("out_reflectance", w.refl, out_reflectance);
				check_field("hit_number", w.num, hit_number);
				check_field("out_hit_count", w.cnt, out_hit_count);
				check_field("zenith_rad", w.zen, zenith_rad);
				check_field("azimuth_rad", w.az, azimuth_rad);
				check_field("out_range", w.rng, out_range);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		scan_item_t rows[$];
		row_kind_t kinds[$];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_MIN_X;
		cfg_data = '0;
		in_valid = 1'b0;
		{action, zenith_deg, azimuth_deg, pos_x, pos_y, pos_z} = '0;
		{hits_in_beam, hit_range, hit_reflectance} = '0;
		box_lo = '{0, 0, 0};
		box_hi = '{0, 0, 0};
		scan_ofs = '{0, 0, 0};
		beam_org = '{0, 0, 0};
		beam_dir = '{0, 0, 0};
		beam_zen = 0;
		beam_az = 0;
		beam_total = 0;
		beam_idx = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under the reset box (a single point at the origin)
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 20'hFFFFF, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_UNUSED, 26'h1FFFFFF, -1, -1, -1, -1, 8'hFF, 20'hFFFFF, '1));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_BEAM, 0, 0, 0, 0, 0, 2, 0, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 0, 32'hA5A5_5A5A));
		kinds.push_back(ROW_MODEL);
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 20'hFFFFF, '1));
		kinds.push_back(ROW_MODEL);
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 0, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_BEAM, 23592960, -23592960, 0, 0, 0, 3, 0, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 0, 1));
		kinds.push_back(ROW_MODEL);
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 1, 2));
		kinds.push_back(ROW_MODEL);
		rows.push_back(mk(ACT_BEAM, 26'h1FFFFFF, 26'h2000000, 0, 0, 0, 1, 0, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 0, 3));
		kinds.push_back(ROW_MODEL);
		rows.push_back(mk(ACT_BEAM, 5898240, 11796480, 0, 0, 0, 1, 0, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 20'hFFFFF, 4));
		kinds.push_back(ROW_MODEL);
		rows.push_back(mk(ACT_OFFSET, 0, 0, C48_MAX, C48_MIN, C48_MAX, 0, 0, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_BEAM, -5898240, 0, C48_MAX, C48_MIN, 0, 255, 0, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 20'hFFFFF, 5));
		kinds.push_back(ROW_MODEL);
		rows.push_back(mk(ACT_OFFSET, 0, 0, 0, 0, 0, 0, 0, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_BEAM, 0, 0, 0, 0, 0, 0, 0, 0));
		kinds.push_back(ROW_NO_POINT);
		rows.push_back(mk(ACT_HIT, 0, 0, 0, 0, 0, 0, 0, 6));
		kinds.push_back(ROW_NO_POINT);
		foreach (rows[i]) send(rows[i], kinds[i]);
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		settle();

		// widest box: every point kept, saturation reachable
		set_box(C48_MIN, C48_MAX);
		random_phase(RANDOM_ITEMS / 2, 1);
		settle();

		// small box around the origin with near coordinates
		set_box(-1048576, 1048576);
		random_phase(RANDOM_ITEMS / 4, 0);
		settle();

		// inverted box keeps nothing
		set_box(C48_MAX, C48_MIN);
		random_phase(50, 0);
		settle();

		// uneven box per axis
		write_box(REG_MIN_X, -2000000);
		write_box(REG_MAX_X, 0);
		write_box(REG_MIN_Y, 0);
		write_box(REG_MAX_Y, 2000000);
		write_box(REG_MIN_Z, -500000);
		write_box(REG_MAX_Z, 500000);
		random_phase(RANDOM_ITEMS / 4, 0);
		settle();

		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/lhxb_pkg.sv
hdl/lhxb_datapath.sv
hdl/lhxb_ctrl.sv
hdl/lidar_hit_to_xyz_box_filter.sv
verif/tb.sv
